/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/blr_pkg.sv */
// ----------------------------------------------------------------------------
// blr_pkg
// Widths, defaults and state encoding of the line rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_W  = 13;   // signed endpoint coordinate
    localparam int DELTA_W  = 14;   // absolute span of one axis
    localparam int TERM_W   = 16;   // signed decision term
    localparam int ADDR_W   = 12;   // linear canvas address
    localparam int COLOR_W  = 32;
    localparam int IDX_W    = 7;    // holds any in-canvas coordinate

    localparam int CANVAS_WIDTH_DEF  = 64;
    localparam int CANVAS_HEIGHT_DEF = 64;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DELTA = 5'b00010,
        ST_ORDER = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_FLUSH = 5'b10000
    } blr_state_t;

endpackage

/* rtl/bresenham_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Walks one line per request with the integer Bresenham decision term and
// emits one pixel write for every visited point that lies on the canvas.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-----------------------------------
//   s_      | in        | s_valid / s_ready  | start_x/y, end_x/y, line_color
//   m_      | out       | m_valid / m_ready  | pixel_address, pixel_color, last
//
// A line request passes through the accept state, the setup states ST_DELTA
// and ST_ORDER, a walk over every point of the major axis (span + 1) and
// the flush state. The walk loop takes one Bresenham step per cycle through
// the term adder unless the walk is held.
// The block takes a new request only when idle; the last pixel of the
// previous line may still sit in the output register at that time.
// A stalled result side holds the walk only when a new on-canvas point finds
// both the held pixel and the output register occupied.
// Reset (aresetn, synchronous, active low) returns the sequencer to idle,
// clears the walk state and empties the output register and the held pixel.
//
// Because the major coordinate rises by one on every step, at most
// CANVAS_WIDTH (x-major) or CANVAS_HEIGHT (y-major) points fall on the
// canvas, so a line on the default 64 x 64 canvas never gives more than 64 writes.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
    parameter int CANVAS_HEIGHT = CANVAS_HEIGHT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_start_x,
    input  logic signed [COORD_W-1:0] s_start_y,
    input  logic signed [COORD_W-1:0] s_end_x,
    input  logic signed [COORD_W-1:0] s_end_y,
    input  logic        [COLOR_W-1:0] s_line_color,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic        [ADDR_W-1:0]  m_pixel_address,
    output logic        [COLOR_W-1:0] m_pixel_color,
    output logic                      m_last_pixel
);

`include "assert_macros.svh"

    // Sequencer.
    blr_state_t state_reg, state_next;

    // Captured request.
    logic signed [COORD_W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [COORD_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic        [COLOR_W-1:0] color_reg, color_next;

    // Spans measured in the first setup cycle.
    logic [DELTA_W-1:0] abs_dx_reg, abs_dx_next, abs_dy_reg, abs_dy_next;
    logic               dx_neg_reg, dx_neg_next, dy_neg_reg, dy_neg_next;

    // Walk state.
    logic signed [COORD_W-1:0] major_pos_reg, major_pos_next;
    logic signed [COORD_W-1:0] minor_pos_reg, minor_pos_next;
    logic signed [COORD_W-1:0] major_end_reg, major_end_next;
    logic signed [TERM_W-1:0]  term_reg, term_next;
    logic        [DELTA_W-1:0] major_delta_reg, major_delta_next;
    logic        [DELTA_W-1:0] minor_delta_reg, minor_delta_next;
    logic                      minor_neg_reg, minor_neg_next;
    logic                      y_major_reg, y_major_next;

    // One on-canvas pixel is held back until the next one is found, so the
    // final write of a line can be marked when the walk ends.
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    logic               out_last_reg, out_last_next;

    // Combinational helpers.
    logic signed [DELTA_W-1:0] dx, dy;
    logic                      swap;
    logic signed [COORD_W-1:0] px, py;
    logic                      hit, out_free, advance, term_pos;
    logic        [ADDR_W-1:0]  addr;
    logic signed [TERM_W:0]    term_sum;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = out_valid_reg;
    assign m_pixel_address = out_addr_reg;
    assign m_pixel_color   = out_color_reg;
    assign m_last_pixel    = out_last_reg;

    assign out_free = !out_valid_reg || m_ready;

    // Spans of the captured request.
    assign dx = DELTA_W'(x1_reg) - DELTA_W'(x0_reg);
    assign dy = DELTA_W'(y1_reg) - DELTA_W'(y0_reg);

    // The endpoints are exchanged when the major coordinate would decrease.
    assign swap = y_major_reg ? dy_neg_reg : dx_neg_reg;

    // Current point on the canvas and its linear address.
    assign px  = y_major_reg ? minor_pos_reg : major_pos_reg;
    assign py  = y_major_reg ? major_pos_reg : minor_pos_reg;
    assign hit = !px[COORD_W-1] && (px[COORD_W-2:0] < (COORD_W-1)'(CANVAS_WIDTH)) &&
                 !py[COORD_W-1] && (py[COORD_W-2:0] < (COORD_W-1)'(CANVAS_HEIGHT));
    assign addr = ADDR_W'(py[IDX_W-1:0]) * ADDR_W'(CANVAS_WIDTH) +
                  ADDR_W'(px[IDX_W-1:0]);

    // One Bresenham step of the decision term.
    assign term_pos = !term_reg[TERM_W-1] && (term_reg != '0);
    assign term_sum = (TERM_W+1)'(term_reg)
                    + $signed((TERM_W+1)'({minor_delta_reg, 1'b0}))
                    - (term_pos ? $signed((TERM_W+1)'({major_delta_reg, 1'b0}))
                                : $signed((TERM_W+1)'(0)));

    // The walk holds only when a new pixel finds both buffers full.
    assign advance = !(hit && pend_valid_reg && !out_free);

    always_comb begin
        state_next       = state_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        color_next       = color_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        dx_neg_next      = dx_neg_reg;
        dy_neg_next      = dy_neg_reg;
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        major_end_next   = major_end_reg;
        term_next        = term_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        minor_neg_next   = minor_neg_reg;
        y_major_next     = y_major_reg;
        pend_valid_next  = pend_valid_reg;
        pend_addr_next   = pend_addr_reg;
        out_valid_next   = out_valid_reg;
        out_addr_next    = out_addr_reg;
        out_color_next   = out_color_reg;
        out_last_next    = out_last_reg;

        // A taken result frees the output register unless refilled below.
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x0_next    = s_start_x;
                    y0_next    = s_start_y;
                    x1_next    = s_end_x;
                    y1_next    = s_end_y;
                    color_next = s_line_color;
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA: begin
                dx_neg_next  = dx[DELTA_W-1];
                dy_neg_next  = dy[DELTA_W-1];
                abs_dx_next  = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
                abs_dy_next  = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
                // Equal spans and the single point walk along y.
                y_major_next = !(abs_dy_next < abs_dx_next);
                state_next   = ST_ORDER;
            end
            ST_ORDER: begin
                if (y_major_reg) begin
                    major_pos_next   = swap ? y1_reg : y0_reg;
                    major_end_next   = swap ? y0_reg : y1_reg;
                    minor_pos_next   = swap ? x1_reg : x0_reg;
                    major_delta_next = abs_dy_reg;
                    minor_delta_next = abs_dx_reg;
                    minor_neg_next   = swap ? (!dx_neg_reg && abs_dx_reg != '0) : dx_neg_reg;
                end else begin
                    major_pos_next   = swap ? x1_reg : x0_reg;
                    major_end_next   = swap ? x0_reg : x1_reg;
                    minor_pos_next   = swap ? y1_reg : y0_reg;
                    major_delta_next = abs_dx_reg;
                    minor_delta_next = abs_dy_reg;
                    minor_neg_next   = swap ? (!dy_neg_reg && abs_dy_reg != '0) : dy_neg_reg;
                end
                term_next  = TERM_W'((TERM_W+1)'({minor_delta_next, 1'b0}) -
                                     (TERM_W+1)'(major_delta_next));
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (advance) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_addr_next  = pend_addr_reg;
                            out_color_next = color_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_addr_next  = addr;
                    end
                    if (term_pos) begin
                        minor_pos_next = minor_neg_reg ? minor_pos_reg - COORD_W'(1)
                                                       : minor_pos_reg + COORD_W'(1);
                    end
                    term_next      = term_sum[TERM_W-1:0];
                    major_pos_next = major_pos_reg + COORD_W'(1);
                    if (major_pos_reg == major_end_reg) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                // The held pixel is the final write of the line.
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = pend_addr_reg;
                    out_color_next  = color_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_end_reg   <= '0;
            term_reg        <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            minor_neg_reg   <= 1'b0;
            y_major_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
            major_pos_reg   <= major_pos_next;
            minor_pos_reg   <= minor_pos_next;
            major_end_reg   <= major_end_next;
            term_reg        <= term_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            minor_neg_reg   <= minor_neg_next;
            y_major_reg     <= y_major_next;
        end
    end

    always_ff @(posedge aclk) begin
        x0_reg          <= x0_next;
        y0_reg          <= y0_next;
        x1_reg          <= x1_next;
        y1_reg          <= y1_next;
        color_reg       <= color_next;
        abs_dx_reg      <= abs_dx_next;
        abs_dy_reg      <= abs_dy_next;
        dx_neg_reg      <= dx_neg_next;
        dy_neg_reg      <= dy_neg_next;
        pend_addr_reg   <= pend_addr_next;
        out_addr_reg    <= out_addr_next;
        out_color_reg   <= out_color_next;
        out_last_reg    <= out_last_next;
    end

    // An idle sequencer never keeps a pixel held back from the last line.
    `ASSERT_IMPLY(a_idle_no_pend, aclk, aresetn, state_reg == ST_IDLE, !pend_valid_reg)

    // The walk never passes the end of the major axis.
    `ASSERT_IMPLY(a_walk_in_span, aclk, aresetn, state_reg == ST_WALK,
                  major_pos_reg <= major_end_reg)

    // Every emitted address lies on the canvas.
    `ASSERT_IMPLY(a_addr_on_canvas, aclk, aresetn, out_valid_reg,
                  int'(out_addr_reg) < CANVAS_WIDTH * CANVAS_HEIGHT)

    // An accepted request always starts the setup sequence.
    `ASSERT_NEXT(a_accept_setup, aclk, aresetn, s_valid && s_ready, state_reg == ST_DELTA)

endmodule

/* dv/bresenham_line_rasterizer_tb.sv */
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_tb
// Sends line requests to the rasterizer and checks every pixel write against
// an in-bench Bresenham walk. A short directed set covers the extremes and the
// clipping corner cases. Random requests follow, with bursty requests on the
// input side and a changing stall pattern on the result side.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blr_pkg::*;

    localparam int CLK_HALF     = 6;          // 12 ns period
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_LINES = 230;
    localparam int DRAIN_CYCLES = 16;
    // The limit leaves room for the slowest legal run: long lines of
    // span 8191, 64 writes per line each waiting out a long stall.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_PRINTED  = 40;
    localparam int CANVAS_W     = CANVAS_WIDTH_DEF;
    localparam int CANVAS_H     = CANVAS_HEIGHT_DEF;
    localparam int MAX_WRITES   = 64;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One expected pixel write, in the order the walk produces them.
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_write_t;

    // Stall patterns of the result side.
    typedef enum int {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_TOGGLE
    } ready_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: walks each accepted line request and queues the pixel
    // writes it must produce; results are matched against the queue head.
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        pixel_write_t pending_pixels[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < MAX_PRINTED) begin
                $display("[%0t] MISMATCH: %s", $time, msg);
            end
            mismatch_count++;
        endtask

        // Integer Bresenham walk along the major axis, clipped to the canvas.
        function void rasterize_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                     logic [COLOR_W-1:0] color);
            int           x0, y0, x1, y1, dx, dy;
            int           a0, b0, a1, b1, swap_tmp;
            int           major_delta, minor_delta, term;
            int           major_pos, minor_pos, px, py, written;
            bit           y_major, step_down, have_held;
            pixel_write_t held;

            x0 = int'(sx);
            y0 = int'(sy);
            x1 = int'(ex);
            y1 = int'(ey);
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            // Equal spans, and so the single point, walk along y.
            y_major = !(dy < dx);
            if (y_major) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            if (a0 > a1) begin
                swap_tmp = a0; a0 = a1; a1 = swap_tmp;
                swap_tmp = b0; b0 = b1; b1 = swap_tmp;
            end
            major_delta = a1 - a0;
            step_down   = (b1 < b0);
            minor_delta = step_down ? b0 - b1 : b1 - b0;
            term        = 2 * minor_delta - major_delta;
            minor_pos   = b0;
            written     = 0;
            have_held   = 0;
            held        = '0;

            for (major_pos = a0; major_pos <= a1; major_pos++) begin
                px = y_major ? minor_pos : major_pos;
                py = y_major ? major_pos : minor_pos;
                if (px >= 0 && px < CANVAS_W && py >= 0 && py < CANVAS_H &&
                    written < MAX_WRITES) begin
                    // Hold one write back so the final one can be marked.
                    if (have_held) begin
                        pending_pixels.push_back(held);
                    end
                    held.address = ADDR_W'(py * CANVAS_W + px);
                    held.color   = color;
                    held.last    = 1'b0;
                    have_held    = 1;
                    written++;
                end
                if (term > 0) begin
                    minor_pos += step_down ? -1 : 1;
                    term      -= 2 * major_delta;
                end
                term += 2 * minor_delta;
            end
            if (have_held) begin
                held.last = 1'b1;
                pending_pixels.push_back(held);
            end
        endfunction

        task check_pixel(logic [ADDR_W-1:0] address, logic [COLOR_W-1:0] color, logic last);
            pixel_write_t want;

            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected write addr=%0d color=%h last=%b",
                                          address, color, last));
                return;
            end
            want = pending_pixels.pop_front();
            if (address !== want.address) begin
                report_mismatch($sformatf("address %0d, want %0d", address, want.address));
            end
            if (color !== want.color) begin
                report_mismatch($sformatf("color %h, want %h (addr %0d)",
                                          color, want.color, want.address));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("last_pixel %b, want %b (addr %0d)",
                                          last, want.last, want.address));
            end
        endtask

        task check_drained();
            pixel_write_t want;

            while (pending_pixels.size() != 0) begin
                want = pending_pixels.pop_front();
                report_mismatch($sformatf("write never came: addr=%0d color=%h last=%b",
                                          want.address, want.color, want.last));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, block inputs and the design under test. All inputs hold known
    // values from time zero.
    // ------------------------------------------------------------------------
    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    coord_t             s_start_x    = '0;
    coord_t             s_start_y    = '0;
    coord_t             s_end_x      = '0;
    coord_t             s_end_y      = '0;
    logic [COLOR_W-1:0] s_line_color = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [ADDR_W-1:0]  m_pixel_address;
    logic [COLOR_W-1:0] m_pixel_color;
    logic               m_last_pixel;

    pixel_scoreboard scoreboard;
    int              burst_left;
    int              cycle_count  = 0;
    ready_mode_t     ready_mode   = RDY_ALWAYS;
    int              mode_left    = 0;

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    bresenham_line_rasterizer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .s_line_color    (s_line_color),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_pixel_color   (m_pixel_color),
        .m_last_pixel    (m_last_pixel)
    );

    // ------------------------------------------------------------------------
    // Request side. Requests go out in bursts; valid is only dropped between
    // bursts, so back-to-back requests in a burst keep valid high and only
    // the payload changes at the accepting edge. Must be called at a rising
    // edge and returns at one.
    // ------------------------------------------------------------------------
    task send_line(int sx, int sy, int ex, int ey, logic [COLOR_W-1:0] color);
        int gap;

        s_valid      <= 1'b1;
        s_start_x    <= coord_t'(sx);
        s_start_y    <= coord_t'(sy);
        s_end_x      <= coord_t'(ex);
        s_end_y      <= coord_t'(ey);
        s_line_color <= color;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // The request was taken at this edge; queue its pixel writes.
        scoreboard.rasterize_line(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
                                  color);

        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // Now and then a long burst gives a stretch with no idling.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    function coord_t pick_coord(int lo, int hi);
        return coord_t'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // Most random lines lie near the canvas and so produce writes with short
    // walks. A few use the full coordinate range; these are slow, since the
    // walk visits every point of the major span.
    task send_random_line();
        int                 kind, x0, y0, d;
        coord_t             sx, sy, ex, ey;
        logic [COLOR_W-1:0] color;

        kind  = $urandom_range(0, 99);
        color = $urandom();
        if (kind < 55) begin
            // Both endpoints in or just around the canvas.
            sx = pick_coord(-20, 83);
            sy = pick_coord(-20, 83);
            ex = pick_coord(-20, 83);
            ey = pick_coord(-20, 83);
        end else if (kind < 70) begin
            // Starts on the canvas and leaves it far away.
            sx = pick_coord(0, CANVAS_W - 1);
            sy = pick_coord(0, CANVAS_H - 1);
            ex = pick_coord(-400, 400);
            ey = pick_coord(-400, 400);
        end else if (kind < 80) begin
            // Horizontal, vertical or exactly diagonal lines.
            x0 = int'(pick_coord(-10, 73));
            y0 = int'(pick_coord(-10, 73));
            d  = int'(pick_coord(-80, 80));
            sx = coord_t'(x0);
            sy = coord_t'(y0);
            case ($urandom_range(0, 2))
                0: begin
                    ex = coord_t'(x0 + d);
                    ey = coord_t'(y0);
                end
                1: begin
                    ex = coord_t'(x0);
                    ey = coord_t'(y0 + d);
                end
                default: begin
                    ex = coord_t'(x0 + d);
                    ey = coord_t'($urandom_range(0, 1) ? y0 + d : y0 - d);
                end
            endcase
        end else if (kind < 92) begin
            // Wholly off the canvas: right of it or above it.
            if ($urandom_range(0, 1)) begin
                sx = pick_coord(CANVAS_W, 200);
                ex = pick_coord(CANVAS_W, 200);
                sy = pick_coord(-100, 100);
                ey = pick_coord(-100, 100);
            end else begin
                sx = pick_coord(-100, 100);
                ex = pick_coord(-100, 100);
                sy = pick_coord(-200, -1);
                ey = pick_coord(-200, -1);
            end
        end else begin
            sx = coord_t'($urandom());
            sy = coord_t'($urandom());
            ex = coord_t'($urandom());
            ey = coord_t'($urandom());
        end
        send_line(int'(sx), int'(sy), int'(ex), int'(ey), color);
    endtask

    // ------------------------------------------------------------------------
    // Result side: checks each accepted write and drives ready from a stall
    // pattern that is drawn anew whenever its run ends. Ready and the outputs
    // are read before this edge's updates take effect.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                scoreboard.check_pixel(m_pixel_address, m_pixel_color, m_last_pixel);
            end
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 200);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RDY_RARELY: m_ready <= ($urandom_range(0, 7) == 0);
                default:    m_ready <= ~m_ready;
            endcase
        end
    end

    // A hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** bresenham_line_rasterizer: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed requests, random requests, drain.
    // ------------------------------------------------------------------------
    initial begin
        scoreboard = new();
        burst_left = 1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single points on two opposite canvas corners, with both extreme colors.
        send_line(0, 0, 0, 0, 32'h0000_0000);
        send_line(63, 63, 63, 63, 32'hFFFF_FFFF);
        // A full row and a full column: exactly 64 writes, the most a line
        // can give. The column is given bottom-up, so the endpoints swap.
        send_line(-100, 0, 200, 0, 32'hAAAA_AAAA);
        send_line(63, 200, 63, -100, 32'h5555_5555);
        // Equal spans walk along y; both diagonals.
        send_line(0, 0, 63, 63, $urandom());
        send_line(63, 0, 0, 63, $urandom());
        // Shallow line given right to left, and a steep one with a falling
        // minor coordinate.
        send_line(60, 10, 3, 25, $urandom());
        send_line(5, 60, 20, 2, $urandom());
        // Off-canvas lines and points just outside three of the borders.
        send_line(-10, -10, -1, -50, $urandom());
        send_line(64, 0, 64, 0, $urandom());
        send_line(-1, 5, -1, 5, $urandom());
        send_line(5, 64, 5, 64, $urandom());
        // Crosses the canvas from the bottom-left to the top-right, clipped on both ends.
        send_line(-5, 70, 70, -5, $urandom());
        // Extreme coordinates: full-span diagonals, axis lines, and a long
        // line that stays off the canvas.
        send_line(-4096, -4096, 4095, 4095, $urandom());
        send_line(4095, -4096, -4096, 4095, $urandom());
        send_line(-4096, 0, 4095, 0, $urandom());
        send_line(0, -4096, 0, 4095, $urandom());
        send_line(4095, 4095, 100, 4095, $urandom());
        // First point off canvas, second on it; then two short lines on the canvas.
        send_line(-1, -1, 0, 0, $urandom());
        send_line(10, 20, 40, 21, $urandom());
        send_line(30, 30, 31, 30, $urandom());

        repeat (RANDOM_LINES) send_random_line();
        s_valid <= 1'b0;

        // Wait for the last writes and for the block to return to idle; a
        // trailing off-canvas line may still be walking with nothing due.
        @(posedge aclk);
        while (scoreboard.pending_pixels.size() != 0 || !s_ready) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        scoreboard.check_drained();

        if (scoreboard.mismatch_count == 0) begin
            $display("** bresenham_line_rasterizer: PASSED **");
        end else begin
            $display("** bresenham_line_rasterizer: FAILED **");
        end
        $finish;
    end

endmodule
